@@ src/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros shared by the checker files
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A signal holds its value over the cycle after cond
`define ASSERT_HOLD(lbl, clk, rst_n, cond, sig, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
    else $error(msg);

`endif

@@ src/pidc_pkg.sv @@
// ---------------------------------------------------------------------------
// pidc_pkg
// Types, register codes and control word layout of the PID position core.
// ---------------------------------------------------------------------------
package pidc_pkg;

  // Sequencer step counter
  localparam int STEP_W    = 4;
  localparam int ROM_DEPTH = 10;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_TARGET  = 3'd0,
    REG_GAIN_P  = 3'd1,
    REG_GAIN_I  = 3'd2,
    REG_GAIN_D  = 3'd3,
    REG_WINDOW  = 3'd4,
    REG_UPPER   = 3'd5,
    REG_LOWER   = 3'd6,
    REG_SCALE   = 3'd7
  } cfg_reg_t;

  // Request opcodes
  localparam logic OP_START  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // Shared multiplier operand pairs
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_SCALE,
    MUL_KP,
    MUL_KI,
    MUL_KD
  } mul_op_t;

  // Accumulator control
  typedef enum logic [1:0] {
    ACC_NONE,
    ACC_LOAD,
    ACC_ADD
  } acc_op_t;

  // Datapath register loads
  typedef enum logic [2:0] {
    DP_NOP,
    DP_AVG,
    DP_ERR,
    DP_STATE,
    DP_OUT,
    DP_START
  } dp_op_t;

  // Jump conditions
  typedef enum logic {
    COND_NONE,
    COND_START
  } cond_t;

  typedef struct packed {
    mul_op_t             mul;
    acc_op_t             acc;
    dp_op_t              dp;
    cond_t               cond;
    logic [STEP_W-1:0]   target;
    logic                emit;
    logic                last;
  } cw_t;

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic is_start;
    logic out_busy;
  } dp_status_t;

  // Configuration register file contents
  typedef struct packed {
    logic signed [31:0] target;
    logic signed [15:0] gain_p;
    logic signed [15:0] gain_i;
    logic signed [15:0] gain_d;
    logic        [30:0] window;
    logic signed [15:0] drive_upper;
    logic signed [15:0] drive_lower;
    logic        [15:0] sensor_scale;
  } cfg_t;

  localparam cw_t CW_NOP = '{
    mul: MUL_NONE, acc: ACC_NONE, dp: DP_NOP, cond: COND_NONE,
    target: '0, emit: 1'b0, last: 1'b0
  };

endpackage

@@ src/pid_position_controller_core.sv @@
// ---------------------------------------------------------------------------
// pid_position_controller_core
// Position PID regulator with integral window reset and drive clamp.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): opcode 0 starts a run, clearing the
//   integral and loading the last error from in_motor_position; opcode 1 is a
//   control sample carrying four Q16.16 position readings.
//   Result channel (out_valid/out_ready): one result per request with the
//   clamped Q8.8 drive, the done flag and the saturated Q16.16 error.
//   Configuration: cfg_we writes cfg_data into register cfg_index at the
//   clock edge; write only while no request is in flight.
//   Timing: a sample runs a nine-word microprogram through the one shared
//   17x48 multiplier and the accumulator; a start request runs the first
//   word and then jumps to the start word. The next request is taken once
//   the sequencer has issued the last word of the current one.
//   The input takes a new request while the previous result waits in the
//   output register; a sequencer reaching its result step with the output
//   still unconsumed holds there until out_ready frees it.
//   Reset (rst_n low, synchronous) restores the register defaults, clears the
//   integral and previous error and drops out_valid.
// ---------------------------------------------------------------------------
module pid_position_controller_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_opcode,
  input  logic signed [31:0] in_motor_position,
  input  logic signed [31:0] in_sensor_a,
  input  logic signed [31:0] in_sensor_b,
  input  logic signed [31:0] in_sensor_c,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_drive,
  output logic               out_done_res,
  output logic signed [31:0] out_error_value,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  pidc_pkg::cfg_t       cfg;
  pidc_pkg::cw_t        cw;
  pidc_pkg::dp_status_t status;
  logic                 busy;
  logic                 accept;

  assign in_ready = !busy;
  assign accept   = in_valid && in_ready;

  pidc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pidc_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (accept),
    .status (status),
    .busy   (busy),
    .cw     (cw)
  );

  pidc_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .cw                (cw),
    .in_load           (accept),
    .in_opcode         (in_opcode),
    .in_motor_position (in_motor_position),
    .in_sensor_a       (in_sensor_a),
    .in_sensor_b       (in_sensor_b),
    .in_sensor_c       (in_sensor_c),
    .status            (status),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_drive         (out_drive),
    .out_done_res      (out_done_res),
    .out_error_value   (out_error_value)
  );

endmodule

@@ src/pidc_cfg.sv @@
// ---------------------------------------------------------------------------
// pidc_cfg
// Configuration register file, written through a plain write port.
// ---------------------------------------------------------------------------
module pidc_cfg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output pidc_pkg::cfg_t     cfg
);

  pidc_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target       <= 32'sd0;
      cfg_r.gain_p       <= 16'sd256;
      cfg_r.gain_i       <= 16'sd0;
      cfg_r.gain_d       <= 16'sd0;
      cfg_r.window       <= 31'd655360;
      cfg_r.drive_upper  <= 16'sd25600;
      cfg_r.drive_lower  <= -16'sd25600;
      cfg_r.sensor_scale <= 16'd256;
    end else if (cfg_we) begin
      case (pidc_pkg::cfg_reg_t'(cfg_index))
        pidc_pkg::REG_TARGET: cfg_r.target       <= cfg_data;
        pidc_pkg::REG_GAIN_P: cfg_r.gain_p       <= cfg_data[15:0];
        pidc_pkg::REG_GAIN_I: cfg_r.gain_i       <= cfg_data[15:0];
        pidc_pkg::REG_GAIN_D: cfg_r.gain_d       <= cfg_data[15:0];
        pidc_pkg::REG_WINDOW: cfg_r.window       <= cfg_data[30:0];
        pidc_pkg::REG_UPPER:  cfg_r.drive_upper  <= cfg_data[15:0];
        pidc_pkg::REG_LOWER:  cfg_r.drive_lower  <= cfg_data[15:0];
        pidc_pkg::REG_SCALE:  cfg_r.sensor_scale <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

@@ src/pidc_seq.sv @@
// ---------------------------------------------------------------------------
// pidc_seq
// Step counter and control store; issues one control word per cycle unless a result step stalls on the output register.
// ---------------------------------------------------------------------------
module pidc_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  pidc_pkg::dp_status_t status,
  output logic                 busy,
  output pidc_pkg::cw_t        cw
);

  logic                          busy_r, busy_nxt;
  logic [pidc_pkg::STEP_W-1:0]   step_r, step_nxt;
  pidc_pkg::cw_t                 rom_word;
  logic                          stall;
  logic                          jump;

  // Control store: sample program at 0..8, start program at 9
  function automatic pidc_pkg::cw_t rom(input logic [pidc_pkg::STEP_W-1:0] a);
    pidc_pkg::cw_t w;
    w = pidc_pkg::CW_NOP;
    case (a)
      4'd0: begin
        w.dp     = pidc_pkg::DP_AVG;
        w.cond   = pidc_pkg::COND_START;
        w.target = 4'(pidc_pkg::ROM_DEPTH - 1);
      end
      4'd1: w.mul = pidc_pkg::MUL_SCALE;
      4'd2: w.dp  = pidc_pkg::DP_ERR;
      4'd3: w.dp  = pidc_pkg::DP_STATE;
      4'd4: w.mul = pidc_pkg::MUL_KP;
      4'd5: begin
        w.mul = pidc_pkg::MUL_KI;
        w.acc = pidc_pkg::ACC_LOAD;
      end
      4'd6: begin
        w.mul = pidc_pkg::MUL_KD;
        w.acc = pidc_pkg::ACC_ADD;
      end
      4'd7: w.acc = pidc_pkg::ACC_ADD;
      4'd8: begin
        w.dp   = pidc_pkg::DP_OUT;
        w.emit = 1'b1;
        w.last = 1'b1;
      end
      4'd9: begin
        w.dp   = pidc_pkg::DP_START;
        w.emit = 1'b1;
        w.last = 1'b1;
      end
      default: w.last = 1'b1;
    endcase
    return w;
  endfunction

  assign rom_word = rom(step_r);
  // Hold a result step while the output register is still occupied
  assign stall    = busy_r && rom_word.emit && status.out_busy;
  assign jump     = (rom_word.cond == pidc_pkg::COND_START) && status.is_start;

  // Step counter and conditional jumps
  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    if (!busy_r) begin
      if (start) begin
        busy_nxt = 1'b1;
        step_nxt = '0;
      end
    end else if (!stall) begin
      if (rom_word.last) begin
        busy_nxt = 1'b0;
      end else if (jump) begin
        step_nxt = rom_word.target;
      end else begin
        step_nxt = step_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
  end

  assign busy = busy_r;
  assign cw   = (busy_r && !stall) ? rom_word : pidc_pkg::CW_NOP;

endmodule

@@ src/pidc_dp.sv @@
// ---------------------------------------------------------------------------
// pidc_dp
// Datapath: request latch, shared multiplier, accumulator, controller state
// and the output register.
// ---------------------------------------------------------------------------
module pidc_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pidc_pkg::cfg_t       cfg,
  input  pidc_pkg::cw_t        cw,
  input  logic                 in_load,
  input  logic                 in_opcode,
  input  logic signed [31:0]   in_motor_position,
  input  logic signed [31:0]   in_sensor_a,
  input  logic signed [31:0]   in_sensor_b,
  input  logic signed [31:0]   in_sensor_c,
  output pidc_pkg::dp_status_t status,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [15:0]   out_drive,
  output logic                 out_done_res,
  output logic signed [31:0]   out_error_value
);

  // Latched request
  logic               op_r;
  logic signed [31:0] motor_r, sa_r, sb_r, sc_r;

  // Working registers
  logic signed [31:0] avg_r, avg_nxt;
  logic signed [64:0] prod_r, prod_nxt;
  logic signed [31:0] err_r, err_nxt;
  logic signed [32:0] deriv_r, deriv_nxt;
  logic               done_r;
  logic signed [65:0] acc_r, acc_nxt;
  logic signed [47:0] integ_r, integ_nxt;
  logic signed [31:0] prev_r;

  // Output register
  logic               out_valid_r;
  logic signed [15:0] out_drive_r, drive_nxt;
  logic               out_done_r;
  logic signed [31:0] out_err_r;

  logic signed [33:0] sum;
  logic signed [16:0] mul_coef;
  logic signed [47:0] mul_opnd;
  logic signed [39:0] scaled;
  logic signed [40:0] diff;
  logic        [31:0] mag;
  logic               in_window;
  logic signed [48:0] isum;
  logic signed [49:0] drv;
  logic signed [49:0] upper, lower;
  logic signed [31:0] target;
  logic signed [15:0] gp, gi, gd;

  assign target = cfg.target;
  assign gp     = cfg.gain_p;
  assign gi     = cfg.gain_i;
  assign gd     = cfg.gain_d;

  // Average of the four readings, floor by arithmetic shift
  assign sum     = 34'(motor_r) + 34'(sa_r) + 34'(sb_r) + 34'(sc_r);
  assign avg_nxt = sum[33:2];

  // Shared multiplier, registered
  always_comb begin
    mul_coef = '0;
    mul_opnd = '0;
    case (cw.mul)
      pidc_pkg::MUL_SCALE: begin
        mul_coef = {1'b0, cfg.sensor_scale};
        mul_opnd = 48'(avg_r);
      end
      pidc_pkg::MUL_KP: begin
        mul_coef = 17'(gp);
        mul_opnd = 48'(err_r);
      end
      pidc_pkg::MUL_KI: begin
        mul_coef = 17'(gi);
        mul_opnd = integ_r;
      end
      pidc_pkg::MUL_KD: begin
        mul_coef = 17'(gd);
        mul_opnd = 48'(deriv_r);
      end
      default: ;
    endcase
  end
  assign prod_nxt = mul_coef * mul_opnd;

  // Error: target minus scaled average, saturated to 32 bits
  assign scaled = prod_r[47:8];
  assign diff   = 41'(target) - 41'(scaled);
  always_comb begin
    if (diff[40:31] == {10{diff[40]}}) begin
      err_nxt = diff[31:0];
    end else if (diff[40]) begin
      err_nxt = 32'sh8000_0000;
    end else begin
      err_nxt = 32'sh7FFF_FFFF;
    end
  end

  // Integral with window reset and 48-bit saturation
  assign mag       = err_r[31] ? 32'(-err_r) : err_r;
  assign in_window = mag < {1'b0, cfg.window};
  assign isum      = 49'(integ_r) + 49'(err_r);
  always_comb begin
    if (!in_window) begin
      integ_nxt = '0;
    end else if (isum[48] != isum[47]) begin
      integ_nxt = isum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    end else begin
      integ_nxt = isum[47:0];
    end
  end
  assign deriv_nxt = 33'(err_r) - 33'(prev_r);

  // Accumulator of the three gain products
  always_comb begin
    case (cw.acc)
      pidc_pkg::ACC_LOAD: acc_nxt = 66'(prod_r);
      pidc_pkg::ACC_ADD:  acc_nxt = acc_r + 66'(prod_r);
      default:            acc_nxt = acc_r;
    endcase
  end

  // Drive: Q8.8 from the accumulator, zero when done, upper limit tested first
  assign drv   = acc_r[65:16];
  assign upper = 50'(cfg.drive_upper);
  assign lower = 50'(cfg.drive_lower);
  always_comb begin
    if (done_r) begin
      drive_nxt = '0;
    end else if (drv > upper) begin
      drive_nxt = cfg.drive_upper;
    end else if (drv < lower) begin
      drive_nxt = cfg.drive_lower;
    end else begin
      drive_nxt = drv[15:0];
    end
  end

  // Request latch and working registers
  always_ff @(posedge clk) begin
    if (in_load) begin
      op_r    <= in_opcode;
      motor_r <= in_motor_position;
      sa_r    <= in_sensor_a;
      sb_r    <= in_sensor_b;
      sc_r    <= in_sensor_c;
    end
    if (cw.dp == pidc_pkg::DP_AVG) avg_r <= avg_nxt;
    if (cw.mul != pidc_pkg::MUL_NONE) prod_r <= prod_nxt;
    if (cw.dp == pidc_pkg::DP_ERR) err_r <= err_nxt;
    if (cw.dp == pidc_pkg::DP_STATE) begin
      deriv_r <= deriv_nxt;
      done_r  <= (err_r == 32'sd0);
    end
    acc_r <= acc_nxt;
  end

  // Controller state: integral and previous error
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
      prev_r  <= '0;
    end else if (cw.dp == pidc_pkg::DP_STATE) begin
      integ_r <= integ_nxt;
      prev_r  <= err_r;
    end else if (cw.dp == pidc_pkg::DP_START) begin
      integ_r <= '0;
      prev_r  <= motor_r;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cw.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cw.dp == pidc_pkg::DP_OUT) begin
      out_drive_r <= drive_nxt;
      out_done_r  <= done_r;
      out_err_r   <= err_r;
    end else if (cw.dp == pidc_pkg::DP_START) begin
      out_drive_r <= '0;
      out_done_r  <= 1'b0;
      out_err_r   <= '0;
    end
  end

  assign status.is_start = (op_r == pidc_pkg::OP_START);
  assign status.out_busy = out_valid_r && !out_ready;

  assign out_valid       = out_valid_r;
  assign out_drive       = out_drive_r;
  assign out_done_res    = out_done_r;
  assign out_error_value = out_err_r;

endmodule

@@ src/pidc_checker.sv @@
// ---------------------------------------------------------------------------
// pidc_checker
// Port-level checks of the PID position core, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pidc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] out_drive,
  input logic               out_done_res,
  input logic signed [31:0] out_error_value
);

  // A stalled result stays offered with its drive unchanged
  `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result dropped")
  `ASSERT_HOLD(a_drive_hold, clk, rst_n, out_valid && !out_ready, out_drive, "drive changed")

  // One request at a time: busy right after acceptance
  `ASSERT_CLK(a_one_req, clk, rst_n, in_valid && in_ready |=> !in_ready, "second request taken")

  // Done means zero error and zero drive
  `ASSERT_CLK(a_done_err, clk, rst_n, out_valid && out_done_res |-> out_error_value == 32'sd0, "done with error")
  `ASSERT_CLK(a_done_drv, clk, rst_n, out_valid && out_done_res |-> out_drive == 16'sd0, "done with drive")

endmodule

bind pid_position_controller_core pidc_checker u_pidc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_drive       (out_drive),
  .out_done_res    (out_done_res),
  .out_error_value (out_error_value)
);
